[src/snc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snc_pkg: shared types and constants of the SPI NOR command framer
// Field widths, flash geometry, action and opcode codes, microcode step and
// condition codes, and the control structures passed between modules.
// ----------------------------------------------------------------------------
package snc_pkg;

    // Flash geometry
    localparam int SECTOR_BITS  = 12;
    localparam int SECTOR_BYTES = 1 << SECTOR_BITS;
    localparam int SECTOR_COUNT = 4096;
    localparam int PAGE_BITS    = 8;
    localparam int PAGE_BYTES   = 1 << PAGE_BITS;

    // Field widths
    localparam int ACT_W  = 3;
    localparam int SEC_W  = 12;
    localparam int OFS_W  = 12;
    localparam int CNT_W  = 13;
    localparam int ADDR_W = 24;
    localparam int OP_W   = 8;

    // Byte count limits
    localparam int TOTAL_CAP = 4096;
    localparam int PROG_CAP  = 16 * PAGE_BYTES;

    // Request actions
    localparam logic [ACT_W-1:0] ACT_READ         = 3'd0;
    localparam logic [ACT_W-1:0] ACT_FAST_READ    = 3'd1;
    localparam logic [ACT_W-1:0] ACT_PROGRAM      = 3'd2;
    localparam logic [ACT_W-1:0] ACT_SECTOR_ERASE = 3'd3;
    localparam logic [ACT_W-1:0] ACT_CHIP_ERASE   = 3'd4;

    // Flash opcodes
    localparam logic [OP_W-1:0] OP_READ         = 8'h03;
    localparam logic [OP_W-1:0] OP_FAST_READ    = 8'h0B;
    localparam logic [OP_W-1:0] OP_PROGRAM      = 8'h02;
    localparam logic [OP_W-1:0] OP_SECTOR_ERASE = 8'h20;
    localparam logic [OP_W-1:0] OP_CHIP_ERASE   = 8'h60;

    // Microcode steps
    localparam int STEP_W = 3;
    localparam logic [STEP_W-1:0] ST_FETCH  = 3'd0;
    localparam logic [STEP_W-1:0] ST_CHECK  = 3'd1;
    localparam logic [STEP_W-1:0] ST_BRANCH = 3'd2;
    localparam logic [STEP_W-1:0] ST_SINGLE = 3'd3;
    localparam logic [STEP_W-1:0] ST_PAGE   = 3'd4;

    // Jump conditions
    localparam int COND_W = 3;
    localparam logic [COND_W-1:0] C_ALWAYS    = 3'd0;
    localparam logic [COND_W-1:0] C_NO_ACCEPT = 3'd1;
    localparam logic [COND_W-1:0] C_SKIP      = 3'd2;
    localparam logic [COND_W-1:0] C_PROGRAM   = 3'd3;
    localparam logic [COND_W-1:0] C_MORE      = 3'd4;

    // One microcode word
    typedef struct packed {
        logic              take;
        logic              emit_single;
        logic              emit_page;
        logic [COND_W-1:0] cond;
        logic [STEP_W-1:0] jmp;
        logic [STEP_W-1:0] nxt;
    } t_ctrl;

    // Strobes from the sequencer to the datapath
    typedef struct packed {
        logic load;
        logic put_single;
        logic put_page;
    } t_cmd;

    // Status from the datapath to the sequencer
    typedef struct packed {
        logic skip;
        logic prog;
        logic more;
        logic out_free;
    } t_stat;

endpackage

[src/snc_ucode_rom.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snc_ucode_rom: microprogram of the command framer
// Read-only table of control words, one per sequencer step.
// ----------------------------------------------------------------------------
module snc_ucode_rom (
    input  logic [snc_pkg::STEP_W-1:0] i_step,
    output snc_pkg::t_ctrl             o_ctrl
);

    // Look up the control word of the current step
    always_comb begin
        o_ctrl = '0;
        unique case (i_step)
            snc_pkg::ST_FETCH: begin
                o_ctrl.take = 1'b1;
                o_ctrl.cond = snc_pkg::C_NO_ACCEPT;
                o_ctrl.jmp  = snc_pkg::ST_FETCH;
                o_ctrl.nxt  = snc_pkg::ST_CHECK;
            end
            snc_pkg::ST_CHECK: begin
                o_ctrl.cond = snc_pkg::C_SKIP;
                o_ctrl.jmp  = snc_pkg::ST_FETCH;
                o_ctrl.nxt  = snc_pkg::ST_BRANCH;
            end
            snc_pkg::ST_BRANCH: begin
                o_ctrl.cond = snc_pkg::C_PROGRAM;
                o_ctrl.jmp  = snc_pkg::ST_PAGE;
                o_ctrl.nxt  = snc_pkg::ST_SINGLE;
            end
            snc_pkg::ST_SINGLE: begin
                o_ctrl.emit_single = 1'b1;
                o_ctrl.cond        = snc_pkg::C_ALWAYS;
                o_ctrl.jmp         = snc_pkg::ST_FETCH;
                o_ctrl.nxt         = snc_pkg::ST_FETCH;
            end
            snc_pkg::ST_PAGE: begin
                o_ctrl.emit_page = 1'b1;
                o_ctrl.cond      = snc_pkg::C_MORE;
                o_ctrl.jmp       = snc_pkg::ST_PAGE;
                o_ctrl.nxt       = snc_pkg::ST_FETCH;
            end
            default: begin
                o_ctrl.cond = snc_pkg::C_ALWAYS;
                o_ctrl.jmp  = snc_pkg::ST_FETCH;
                o_ctrl.nxt  = snc_pkg::ST_FETCH;
            end
        endcase
    end

endmodule

[src/snc_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snc_datapath: request registers and descriptor output stage
// Holds the current request, steps address, remaining and done counts one
// page at a time, and keeps the descriptor until the consumer takes it.
// ----------------------------------------------------------------------------
module snc_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  snc_pkg::t_cmd                 i_cmd,
    output snc_pkg::t_stat                o_stat,
    input  logic [snc_pkg::ACT_W-1:0]     i_action,
    input  logic [snc_pkg::SEC_W-1:0]     i_sector_number,
    input  logic [snc_pkg::OFS_W-1:0]     i_byte_offset,
    input  logic [snc_pkg::CNT_W-1:0]     i_byte_total,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [snc_pkg::OP_W-1:0]      o_opcode,
    output logic [snc_pkg::ADDR_W-1:0]    o_flash_address,
    output logic [snc_pkg::CNT_W-1:0]     o_transfer_bytes,
    output logic [snc_pkg::CNT_W-1:0]     o_buffer_index,
    output logic                          o_dummy_bytes,
    output logic                          o_enable_write_first,
    output logic                          o_poll_busy,
    output logic                          o_final_res
);

    // Request registers
    logic [snc_pkg::ACT_W-1:0]  r_action;
    logic [snc_pkg::ADDR_W-1:0] r_base;
    logic [snc_pkg::ADDR_W-1:0] r_addr;
    logic [snc_pkg::CNT_W-1:0]  r_left;
    logic [snc_pkg::CNT_W-1:0]  r_done;

    // Output stage
    logic                       r_out_valid;
    logic [snc_pkg::OP_W-1:0]   r_opcode;
    logic [snc_pkg::ADDR_W-1:0] r_flash_address;
    logic [snc_pkg::CNT_W-1:0]  r_transfer_bytes;
    logic [snc_pkg::CNT_W-1:0]  r_buffer_index;
    logic                       r_dummy_bytes;
    logic                       r_enable_write_first;
    logic                       r_poll_busy;
    logic                       r_final_res;
    logic                       n_out_valid;

    logic [snc_pkg::SEC_W-1:0]  w_sector;
    logic [snc_pkg::ADDR_W-1:0] w_base;
    logic [snc_pkg::CNT_W-1:0]  w_total;
    logic [snc_pkg::CNT_W-1:0]  w_page_room;
    logic [snc_pkg::CNT_W-1:0]  w_seg;

    // Form the start address and clamp the byte count of a new request
    always_comb begin
        w_sector = snc_pkg::SEC_W'(i_sector_number % snc_pkg::SECTOR_COUNT);
        w_base   = snc_pkg::ADDR_W'(32'(w_sector) << snc_pkg::SECTOR_BITS);
        w_total  = i_byte_total;
        if (w_total > snc_pkg::CNT_W'(snc_pkg::TOTAL_CAP)) begin
            w_total = snc_pkg::CNT_W'(snc_pkg::TOTAL_CAP);
        end
        if ((i_action == snc_pkg::ACT_PROGRAM)
            && (w_total > snc_pkg::CNT_W'(snc_pkg::PROG_CAP))) begin
            w_total = snc_pkg::CNT_W'(snc_pkg::PROG_CAP);
        end
    end

    // Segment: bytes up to the next page boundary, limited to what is left
    always_comb begin
        w_page_room = snc_pkg::CNT_W'(snc_pkg::PAGE_BYTES)
                    - snc_pkg::CNT_W'(r_addr[snc_pkg::PAGE_BITS-1:0]);
        w_seg = (w_page_room > r_left) ? r_left : w_page_room;
    end

    // Status for the sequencer's jumps
    always_comb begin
        o_stat.skip     = (r_action > snc_pkg::ACT_CHIP_ERASE)
                        || ((r_action == snc_pkg::ACT_PROGRAM)
                            && (r_left == '0));
        o_stat.prog     = (r_action == snc_pkg::ACT_PROGRAM);
        o_stat.more     = (r_left != w_seg);
        o_stat.out_free = !r_out_valid || i_out_ready;
    end

    // Load a request, then advance one page per emitted segment
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_action;
            r_base   <= w_base;
            r_addr   <= w_base + snc_pkg::ADDR_W'(i_byte_offset);
            r_left   <= w_total;
            r_done   <= '0;
        end else if (i_cmd.put_page) begin
            r_addr <= r_addr + snc_pkg::ADDR_W'(w_seg);
            r_left <= r_left - w_seg;
            r_done <= r_done + w_seg;
        end
    end

    // Hold the descriptor until the consumer takes it
    always_comb begin
        n_out_valid = r_out_valid;
        if (i_cmd.put_single || i_cmd.put_page) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    // Fill the descriptor fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.put_page) begin
            r_opcode             <= snc_pkg::OP_PROGRAM;
            r_flash_address      <= r_addr;
            r_transfer_bytes     <= w_seg;
            r_buffer_index       <= r_done;
            r_dummy_bytes        <= 1'b0;
            r_enable_write_first <= 1'b1;
            r_poll_busy          <= 1'b1;
            r_final_res          <= !o_stat.more;
        end else if (i_cmd.put_single) begin
            r_buffer_index <= '0;
            r_final_res    <= 1'b1;
            unique case (r_action)
                snc_pkg::ACT_READ: begin
                    r_opcode             <= snc_pkg::OP_READ;
                    r_flash_address      <= r_addr;
                    r_transfer_bytes     <= r_left;
                    r_dummy_bytes        <= 1'b0;
                    r_enable_write_first <= 1'b0;
                    r_poll_busy          <= 1'b0;
                end
                snc_pkg::ACT_FAST_READ: begin
                    r_opcode             <= snc_pkg::OP_FAST_READ;
                    r_flash_address      <= r_addr;
                    r_transfer_bytes     <= r_left;
                    r_dummy_bytes        <= 1'b1;
                    r_enable_write_first <= 1'b0;
                    r_poll_busy          <= 1'b0;
                end
                snc_pkg::ACT_SECTOR_ERASE: begin
                    r_opcode             <= snc_pkg::OP_SECTOR_ERASE;
                    r_flash_address      <= r_base;
                    r_transfer_bytes     <= '0;
                    r_dummy_bytes        <= 1'b0;
                    r_enable_write_first <= 1'b1;
                    r_poll_busy          <= 1'b1;
                end
                default: begin
                    r_opcode             <= snc_pkg::OP_CHIP_ERASE;
                    r_flash_address      <= '0;
                    r_transfer_bytes     <= '0;
                    r_dummy_bytes        <= 1'b0;
                    r_enable_write_first <= 1'b1;
                    r_poll_busy          <= 1'b1;
                end
            endcase
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_opcode             = r_opcode;
    assign o_flash_address      = r_flash_address;
    assign o_transfer_bytes     = r_transfer_bytes;
    assign o_buffer_index       = r_buffer_index;
    assign o_dummy_bytes        = r_dummy_bytes;
    assign o_enable_write_first = r_enable_write_first;
    assign o_poll_busy          = r_poll_busy;
    assign o_final_res          = r_final_res;

endmodule

[src/spi_nor_command_framer_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi_nor_command_framer_core: SPI NOR command descriptor framer
// Turns one flash request into SPI NOR command descriptors, splitting
// programs at page boundaries, under a small microcoded sequencer.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                | payload
//  ---------+-----------+--------------------------+---------------------------
//  request  | in        | i_in_valid / o_in_ready  | action, sector, offset, total
//  command  | out       | o_out_valid / i_out_ready| opcode, address, counts, flags
//
//  A request is taken only at the fetch step; the next one is taken after
//  its last descriptor has been loaded into the output register. Reads and
//  erases end with the single step, programs with one page step per page
//  (up to 17 pages); unknown actions and empty programs return to fetch at
//  the check step. The step counter emits one page descriptor per cycle at
//  the page step while the output register is free; a full output register
//  stalls the emitting step until the consumer takes it. Reset (synchronous,
//  active low) returns to the fetch step and empties the output register.
// ----------------------------------------------------------------------------
module spi_nor_command_framer_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_action,
    input  logic [11:0] i_sector_number,
    input  logic [11:0] i_byte_offset,
    input  logic [12:0] i_byte_total,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_opcode,
    output logic [23:0] o_flash_address,
    output logic [12:0] o_transfer_bytes,
    output logic [12:0] o_buffer_index,
    output logic        o_dummy_bytes,
    output logic        o_enable_write_first,
    output logic        o_poll_busy,
    output logic        o_final_res
);

    logic [snc_pkg::STEP_W-1:0] r_step;
    logic [snc_pkg::STEP_W-1:0] n_step;
    snc_pkg::t_ctrl             w_ctrl;
    snc_pkg::t_cmd              w_cmd;
    snc_pkg::t_stat             w_stat;
    logic                       w_accept;
    logic                       w_cond;
    logic                       w_stall;

    snc_ucode_rom u_rom (
        .i_step (r_step),
        .o_ctrl (w_ctrl)
    );

    // Evaluate the jump condition of the current word
    always_comb begin
        case (w_ctrl.cond)
            snc_pkg::C_ALWAYS:    w_cond = 1'b1;
            snc_pkg::C_NO_ACCEPT: w_cond = !w_accept;
            snc_pkg::C_SKIP:      w_cond = w_stat.skip;
            snc_pkg::C_PROGRAM:   w_cond = w_stat.prog;
            snc_pkg::C_MORE:      w_cond = w_stat.more;
            default:              w_cond = 1'b1;
        endcase
    end

    // Gate strobes and pick the next step; hold while the output is full
    always_comb begin
        w_accept         = i_in_valid && w_ctrl.take;
        w_stall          = (w_ctrl.emit_single || w_ctrl.emit_page) && !w_stat.out_free;
        w_cmd.load       = w_accept;
        w_cmd.put_single = w_ctrl.emit_single && w_stat.out_free;
        w_cmd.put_page   = w_ctrl.emit_page && w_stat.out_free;
        if (w_stall) begin
            n_step = r_step;
        end else if (w_cond) begin
            n_step = w_ctrl.jmp;
        end else begin
            n_step = w_ctrl.nxt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= snc_pkg::ST_FETCH;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_in_ready = w_ctrl.take;

    snc_datapath u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (w_cmd),
        .o_stat               (w_stat),
        .i_action             (i_action),
        .i_sector_number      (i_sector_number),
        .i_byte_offset        (i_byte_offset),
        .i_byte_total         (i_byte_total),
        .o_out_valid          (o_out_valid),
        .i_out_ready          (i_out_ready),
        .o_opcode             (o_opcode),
        .o_flash_address      (o_flash_address),
        .o_transfer_bytes     (o_transfer_bytes),
        .o_buffer_index       (o_buffer_index),
        .o_dummy_bytes        (o_dummy_bytes),
        .o_enable_write_first (o_enable_write_first),
        .o_poll_busy          (o_poll_busy),
        .o_final_res          (o_final_res)
    );

    // A request is only ever taken at the fetch step
    a_accept_at_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |-> (r_step == snc_pkg::ST_FETCH))
        else $error("request taken outside the fetch step");

    // Loading, single emission and page emission never coincide
    a_one_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.load, w_cmd.put_single, w_cmd.put_page}))
        else $error("conflicting datapath strobes");

    // After the last descriptor of a request, return to fetch
    a_last_returns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.put_single || (w_cmd.put_page && !w_stat.more))
        |=> (r_step == snc_pkg::ST_FETCH))
        else $error("sequencer did not return to fetch after last descriptor");

    // A descriptor that is loaded always carries the final flag on single steps
    a_single_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.put_single |=> (o_out_valid && o_final_res))
        else $error("single descriptor not marked final");

endmodule
